@@ rtl/core/twr_pkg.sv @@
// Package for the text word wrap block: field widths, character codes,
// register indexes and the types shared by the front, back and top level.
`timescale 1ns / 1ps

package twr_pkg;

  localparam int CHAR_W     = 8;
  localparam int POS_W      = 16;
  localparam int ADV_W      = 10;
  localparam int BOX_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int NEED_W     = POS_W + 1 + ADV_W;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_ADVANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE   = 2'd2;

  localparam logic [ADV_W-1:0] GLYPH_ADVANCE_RST = 10'd8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  // break passes per character before the character is given up
  localparam logic [2:0] MAX_ITER = 3'd6;
  // descriptors kept per character
  localparam logic [1:0] MAX_KEEP = 2'd3;

  typedef enum logic [2:0] {
    KIND_EMPTY,
    KIND_NEWLINE,
    KIND_RETURN,
    KIND_SPACE,
    KIND_GLYPH
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [ADV_W-1:0] glyph_advance;
    logic [BOX_W-1:0] box_width;
    logic             wrap_enable;
  } cfg_t;

endpackage

@@ rtl/core/text_word_wrap.sv @@
// Greedy word wrap over a character stream: one character per input word,
// one line descriptor (start offset, length, final-line flag) per output
// word. An ordinary character, a newline, a carriage return, an empty-text
// word or a break at a space is finished by the back without a break pass.
// A character that breaks the line before itself (after the last space, or
// inside a word with no space) takes one break pass per line that break
// produces, up to six break passes; a character that uses all six is then
// dropped. The single break/count unit with its glyph-width multiplier
// handles one line per cycle while the output does not stall the back.
// A line is handed to the output through a pending slot and an output
// register, so up to two descriptors can wait while new characters are
// still taken into the input queue; a further descriptor stalls the back
// until the receiver takes a word. Configuration takes effect once it is
// stored, even between passes. Depends on twr_pkg, twr_front and twr_back.
`timescale 1ns / 1ps

module text_word_wrap #(
  parameter int QUEUE_DEPTH = twr_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [twr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [twr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [twr_pkg::CHAR_W-1:0]     char_code_i,
  input  logic                          is_last_i,
  input  logic                          text_empty_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [twr_pkg::POS_W-1:0]      line_start_o,
  output logic [twr_pkg::POS_W-1:0]      line_length_o,
  output logic                          last_line_o
);

  twr_pkg::cfg_t    cfg_q;
  twr_pkg::q_head_t head;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_advance <= twr_pkg::GLYPH_ADVANCE_RST;
      cfg_q.box_width     <= '0;
      cfg_q.wrap_enable   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        twr_pkg::REG_GLYPH_ADVANCE: cfg_q.glyph_advance <= cfg_data_i[twr_pkg::ADV_W-1:0];
        twr_pkg::REG_BOX_WIDTH:     cfg_q.box_width     <= cfg_data_i[twr_pkg::BOX_W-1:0];
        twr_pkg::REG_WRAP_ENABLE:   cfg_q.wrap_enable   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  twr_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .text_empty_i(text_empty_i),
    .head_o      (head),
    .pop_i       (pop)
  );

  twr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_start_o (line_start_o),
    .line_length_o(line_length_o),
    .last_line_o  (last_line_o)
  );

endmodule

@@ rtl/core/twr_front.sv @@
// Front of the word wrap block: classifies each incoming character and
// holds it in a short queue for the back. Depends on twr_pkg.
`timescale 1ns / 1ps

module twr_front #(
  parameter int DEPTH = twr_pkg::QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [twr_pkg::CHAR_W-1:0] char_code_i,
  input  logic                      is_last_i,
  input  logic                      text_empty_i,
  output twr_pkg::q_head_t          head_o,
  input  logic                      pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  twr_pkg::item_t  mem_q [DEPTH];
  twr_pkg::item_t  item_in;
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push;

  always_comb begin
    item_in.last = is_last_i;
    priority if (text_empty_i) begin
      item_in.kind = twr_pkg::KIND_EMPTY;
    end else if (char_code_i == twr_pkg::CH_NEWLINE) begin
      item_in.kind = twr_pkg::KIND_NEWLINE;
    end else if (char_code_i == twr_pkg::CH_RETURN) begin
      item_in.kind = twr_pkg::KIND_RETURN;
    end else if (char_code_i == twr_pkg::CH_SPACE) begin
      item_in.kind = twr_pkg::KIND_SPACE;
    end else begin
      item_in.kind = twr_pkg::KIND_GLYPH;
    end
  end

  assign in_ready_o = (cnt_q != CW'(DEPTH));
  assign push       = in_valid_i & in_ready_o;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    unique case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_in;
    end
  end

endmodule

@@ rtl/core/twr_back.sv @@
// Back of the word wrap block: line state, break decision and descriptor
// output stage (one pending slot plus output register). Depends on twr_pkg.
`timescale 1ns / 1ps

module twr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  twr_pkg::cfg_t              cfg_i,
  input  twr_pkg::q_head_t           head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [twr_pkg::POS_W-1:0]  line_start_o,
  output logic [twr_pkg::POS_W-1:0]  line_length_o,
  output logic                       last_line_o
);

  localparam int PW = twr_pkg::POS_W;
  localparam int NW = twr_pkg::NEED_W;

  // line state
  logic [PW-1:0] pos_q, pos_d, start_q, start_d, count_q, count_d;
  logic [PW-1:0] asp_q, asp_d, tail_q, tail_d;
  logic          sseen_q, sseen_d, lsr_q, lsr_d, force_q, force_d;
  logic          emitted_q, emitted_d;
  logic [2:0]    iter_q, iter_d;
  logic [1:0]    nput_q, nput_d;

  // pending descriptor and output register
  logic          pend_v_q, pend_done_q, pend_last_q;
  logic [PW-1:0] pend_start_q, pend_len_q;
  logic          out_v_q, out_last_q;
  logic [PW-1:0] out_start_q, out_len_q;

  twr_pkg::kind_e kind;
  logic          last, is_space;
  logic [PW:0]   cnt_inc;
  logic [NW-1:0] need;
  logic          wrap_hit;
  logic          put, done, closed, do_open, carry, flag, keep, go, stall;
  logic          out_free, pend_mv, clear;
  logic [PW-1:0] put_start, put_len, open_at;

  assign kind     = head_i.item.kind;
  assign last     = head_i.item.last;
  assign is_space = (kind == twr_pkg::KIND_SPACE);

  assign cnt_inc  = {1'b0, count_q} + 1'b1;
  assign need     = NW'(cnt_inc) * NW'(cfg_i.glyph_advance);
  assign wrap_hit = cfg_i.wrap_enable & (need > NW'(cfg_i.box_width)) & ~force_q;

  always_comb begin
    pos_d     = pos_q;
    start_d   = start_q;
    count_d   = count_q;
    asp_d     = asp_q;
    sseen_d   = sseen_q;
    tail_d    = tail_q;
    lsr_d     = lsr_q;
    force_d   = force_q;
    emitted_d = emitted_q;
    iter_d    = iter_q;
    put       = 1'b0;
    put_start = start_q;
    put_len   = count_q;
    done      = 1'b0;
    closed    = 1'b0;
    do_open   = 1'b0;
    carry     = 1'b0;
    open_at   = '0;

    unique case (kind)
      twr_pkg::KIND_EMPTY: begin
        put       = 1'b1;
        put_start = '0;
        put_len   = '0;
        done      = 1'b1;
      end
      twr_pkg::KIND_NEWLINE: begin
        put     = 1'b1;
        do_open = 1'b1;
        open_at = pos_q + 1'b1;
        closed  = 1'b1;
        done    = 1'b1;
      end
      twr_pkg::KIND_RETURN: begin
        done = 1'b1;
      end
      twr_pkg::KIND_SPACE, twr_pkg::KIND_GLYPH: begin
        if (iter_q == twr_pkg::MAX_ITER) begin
          // break passes used up: drop the character
          done = 1'b1;
        end else if (wrap_hit) begin
          if (count_q == '0) force_d = 1'b1;
          if (is_space) begin
            put     = 1'b1;
            put_len = pos_q - start_q;
            do_open = 1'b1;
            open_at = pos_q + 1'b1;
            closed  = 1'b1;
            done    = 1'b1;
          end else if (sseen_q) begin
            // break after the last space, carry the tail over
            put     = 1'b1;
            put_len = asp_q - start_q;
            do_open = 1'b1;
            open_at = asp_q;
            carry   = 1'b1;
            iter_d  = iter_q + 1'b1;
          end else begin
            put     = 1'b1;
            do_open = 1'b1;
            open_at = pos_q;
            iter_d  = iter_q + 1'b1;
          end
        end else begin
          force_d = 1'b0;
          if (is_space) begin
            sseen_d = 1'b1;
            asp_d   = pos_q + 1'b1;
            tail_d  = '0;
          end
          if (cfg_i.wrap_enable && pos_q == start_q && is_space && emitted_q && !lsr_q) begin
            start_d = pos_q + 1'b1;
            lsr_d   = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
            if (!is_space) tail_d = tail_q + 1'b1;
          end
          done = 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase

    if (do_open) begin
      start_d = open_at;
      count_d = '0;
      sseen_d = 1'b0;
      asp_d   = '0;
      tail_d  = '0;
      lsr_d   = 1'b0;
    end
    if (carry) begin
      count_d = tail_q;
      tail_d  = tail_q;
      if (tail_q != '0) force_d = 1'b0;
    end

    // text end closes the open line unless this character closed one
    if (done && last && kind != twr_pkg::KIND_EMPTY && !closed) begin
      put       = 1'b1;
      put_start = start_d;
      put_len   = count_d;
    end
    if (put) emitted_d = 1'b1;

    flag  = (kind == twr_pkg::KIND_EMPTY) | last;
    clear = done & flag;
    if (done) begin
      iter_d = '0;
      pos_d  = pos_q + 1'b1;
    end
    if (clear) begin
      pos_d     = '0;
      start_d   = '0;
      count_d   = '0;
      asp_d     = '0;
      sseen_d   = 1'b0;
      tail_d    = '0;
      lsr_d     = 1'b0;
      force_d   = 1'b0;
      emitted_d = 1'b0;
    end
  end

  assign keep     = put & (nput_q != twr_pkg::MAX_KEEP);
  assign out_free = ~out_v_q | out_ready_i;
  assign stall    = keep & pend_v_q & ~out_free;
  assign go       = head_i.valid & ~stall;
  assign pop_o    = go & done;
  assign pend_mv  = pend_v_q & out_free & (pend_done_q | (go & keep));
  assign nput_d   = done ? '0 : nput_q + {1'b0, keep};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      start_q   <= '0;
      count_q   <= '0;
      asp_q     <= '0;
      sseen_q   <= 1'b0;
      tail_q    <= '0;
      lsr_q     <= 1'b0;
      force_q   <= 1'b0;
      emitted_q <= 1'b0;
      iter_q    <= '0;
      nput_q    <= '0;
    end else if (go) begin
      pos_q     <= pos_d;
      start_q   <= start_d;
      count_q   <= count_d;
      asp_q     <= asp_d;
      sseen_q   <= sseen_d;
      tail_q    <= tail_d;
      lsr_q     <= lsr_d;
      force_q   <= force_d;
      emitted_q <= emitted_d;
      iter_q    <= iter_d;
      nput_q    <= nput_d;
    end
  end

  // pending slot: the newest descriptor of a character waits here until the
  // character is finished, so the final-line flag can still land on it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      pend_done_q <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (go && keep) begin
        pend_v_q    <= 1'b1;
        pend_done_q <= done;
      end else begin
        if (pend_mv) pend_v_q <= 1'b0;
        if (go && done && nput_q != '0) pend_done_q <= 1'b1;
      end
      if (pend_mv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && keep) begin
      pend_start_q <= put_start;
      pend_len_q   <= put_len;
      pend_last_q  <= done & flag;
    end else if (go && done && nput_q != '0) begin
      pend_last_q  <= flag;
    end
    if (pend_mv) begin
      out_start_q <= pend_start_q;
      out_len_q   <= pend_len_q;
      out_last_q  <= pend_last_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign line_start_o  = out_start_q;
  assign line_length_o = out_len_q;
  assign last_line_o   = out_last_q;

endmodule

@@ rtl/core/twr_checker.sv @@
// Port-level checks for text_word_wrap, attached by the bind below.
// Depends on twr_pkg for port widths.
`timescale 1ns / 1ps

module twr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [twr_pkg::CHAR_W-1:0]     char_code_i,
  input logic                          is_last_i,
  input logic                          text_empty_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [twr_pkg::POS_W-1:0]      line_start_o,
  input logic [twr_pkg::POS_W-1:0]      line_length_o,
  input logic                          last_line_o
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_start_o) &&
      $stable(line_length_o) && $stable(last_line_o))
    else $error("stalled output word changed");

  // hold an input word until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(char_code_i) &&
      $stable(is_last_i) && $stable(text_empty_i))
    else $error("waiting input word changed");

  // the queue fills only on an accepted word
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("input ready dropped without an accepted word");

  // leave reset empty and open for input
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_ready_o && !out_valid_o)
    else $error("block not empty after reset");

endmodule

bind text_word_wrap twr_checker u_twr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .char_code_i  (char_code_i),
  .is_last_i    (is_last_i),
  .text_empty_i (text_empty_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .line_start_o (line_start_o),
  .line_length_o(line_length_o),
  .last_line_o  (last_line_o)
);
